// ----- hdl/rcpw_pkg.sv -----
// ----------------------------------------------------------------------------
// RC pulse width capture package
// Shared constants, register codes and record types of the capture block.
// ----------------------------------------------------------------------------
package rcpw_pkg;

  // Number of capture channels and the width of a channel index in storage.
  localparam int NUM_CHANNELS = 4;
  localparam int ChIdxW       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Fixed field widths.
  localparam int ChanW = 2;
  localparam int TimeW = 16;
  localparam int CfgIdxW = 2;

  // Reset values.
  localparam logic [TimeW-1:0] MinOnReset    = 16'd950;
  localparam logic [TimeW-1:0] MaxOnReset    = 16'd2075;
  localparam logic [TimeW-1:0] MinOffReset   = 16'd1000;
  localparam logic [TimeW-1:0] MaxOffReset   = 16'd22000;
  localparam logic [TimeW-1:0] WidthReset    = 16'd1500;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_ON  = 2'd0,
    CFG_MAX_ON  = 2'd1,
    CFG_MIN_OFF = 2'd2,
    CFG_MAX_OFF = 2'd3
  } cfg_idx_e;

  // Request codes.
  localparam logic REQ_EDGE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Acceptance windows.
  typedef struct packed {
    logic [TimeW-1:0] min_on;
    logic [TimeW-1:0] max_on;
    logic [TimeW-1:0] min_off;
    logic [TimeW-1:0] max_off;
  } window_cfg_t;

  // Per-channel state record.
  typedef struct packed {
    logic             phase;   // 1: waiting for the falling edge
    logic [TimeW-1:0] rise;
    logic [TimeW-1:0] fall;
    logic [TimeW-1:0] width;
  } chan_state_t;

endpackage

// ----- hdl/rcpw_edge_eval.sv -----
// ----------------------------------------------------------------------------
// RC pulse width edge evaluator
// Computes the next state of one channel for an edge event or a read.
// ----------------------------------------------------------------------------
module rcpw_edge_eval (
  input  rcpw_pkg::chan_state_t       cur_i,
  input  rcpw_pkg::window_cfg_t       cfg_i,
  input  logic                        req_type_i,
  input  logic [rcpw_pkg::TimeW-1:0]  edge_time_i,
  output rcpw_pkg::chan_state_t       nxt_o,
  output logic                        updated_o
);
  import rcpw_pkg::*;

  logic [TimeW-1:0] older;
  logic [TimeW-1:0] diff;
  logic [TimeW-1:0] span;
  logic             in_on_win;
  logic             in_off_win;

  // Interval since the older time; a non-increasing pair wraps through 0xFFFF,
  // which is the plain difference less one.
  always_comb begin
    older = cur_i.phase ? cur_i.rise : cur_i.fall;
    diff  = edge_time_i - older;
    span  = (edge_time_i > older) ? diff : (diff - TimeW'(1));
  end

  assign in_on_win  = (span >= cfg_i.min_on)  && (span <= cfg_i.max_on);
  assign in_off_win = (span >= cfg_i.min_off) && (span <= cfg_i.max_off);

  // Next state: an edge always stores its time, phase and width follow the window; a read leaves the state unchanged.
  always_comb begin
    nxt_o     = cur_i;
    updated_o = 1'b0;
    if (req_type_i == REQ_EDGE) begin
      if (!cur_i.phase) begin
        nxt_o.rise = edge_time_i;
        if (in_off_win) begin
          nxt_o.phase = 1'b1;
        end
      end else begin
        nxt_o.fall = edge_time_i;
        if (in_on_win) begin
          nxt_o.width = span;
          nxt_o.phase = 1'b0;
          updated_o   = 1'b1;
        end
      end
    end
  end

endmodule

// ----- hdl/rc_pwm_pulse_width_capture.sv -----
// ----------------------------------------------------------------------------
// RC servo pulse width capture
// Decodes servo pulse widths on several channels from timestamped edges.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  input     in_valid_i / in_stall_o   req_type_i, chan_index_i, edge_time_i
//  output    out_valid_o / out_stall_i out_chan_o, pulse_width_o,
//                                      width_updated_o, awaiting_fall_o
//  config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
//  One transaction per clock sustained while the output is not stalled; a
//  transaction passes through the input register, then the channel
//  read-modify-write into the result register. Channel state lives in
//  flip-flops and is updated in the same cycle it is read, so back-to-back
//  transactions on one channel chain. Reset restores the window registers
//  and all channel state at once. A stalled output holds its result; the
//  input stalls only when both registers are full.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_width_capture (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          req_type_i,
  input  logic [rcpw_pkg::ChanW-1:0]    chan_index_i,
  input  logic [rcpw_pkg::TimeW-1:0]    edge_time_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rcpw_pkg::ChanW-1:0]    out_chan_o,
  output logic [rcpw_pkg::TimeW-1:0]    pulse_width_o,
  output logic                          width_updated_o,
  output logic                          awaiting_fall_o,
  // Configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rcpw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rcpw_pkg::TimeW-1:0]    cfg_data_i
);
  import rcpw_pkg::*;

  localparam int ChanExtW = (ChIdxW > ChanW) ? ChIdxW : ChanW;

  window_cfg_t      cfg_q;
  chan_state_t      state_q [NUM_CHANNELS];

  logic             s1_valid_q;
  logic             s1_req_q;
  logic [ChanW-1:0] s1_chan_q;
  logic [TimeW-1:0] s1_time_q;

  logic             out_valid_q;
  logic [ChanW-1:0] out_chan_q;
  logic [TimeW-1:0] out_width_q;
  logic             out_upd_q;
  logic             out_fall_q;

  logic                s1_adv;
  logic                in_acc;
  logic [ChanExtW-1:0] chan_ext;
  logic [ChIdxW-1:0]   ch_idx;
  logic                in_range;
  chan_state_t         cur_state;
  chan_state_t         nxt_state;
  logic                updated;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_on  <= MinOnReset;
      cfg_q.max_on  <= MaxOnReset;
      cfg_q.min_off <= MinOffReset;
      cfg_q.max_off <= MaxOffReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_ON:  cfg_q.min_on  <= cfg_data_i;
        CFG_MAX_ON:  cfg_q.max_on  <= cfg_data_i;
        CFG_MIN_OFF: cfg_q.min_off <= cfg_data_i;
        CFG_MAX_OFF: cfg_q.max_off <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline flow control: stage one moves on when the result slot frees up.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc || s1_adv) begin
      s1_valid_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_req_q  <= req_type_i;
      s1_chan_q <= chan_index_i;
      s1_time_q <= edge_time_i;
    end
  end

  // Channel selection.
  always_comb begin
    chan_ext  = ChanExtW'(s1_chan_q);
    ch_idx    = chan_ext[ChIdxW-1:0];
    in_range  = (int'(s1_chan_q) < NUM_CHANNELS);
    cur_state = state_q[ch_idx];
  end

  rcpw_edge_eval u_eval (
    .cur_i       (cur_state),
    .cfg_i       (cfg_q),
    .req_type_i  (s1_req_q),
    .edge_time_i (s1_time_q),
    .nxt_o       (nxt_state),
    .updated_o   (updated)
  );

  // Channel state write-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        state_q[c].phase <= 1'b0;
        state_q[c].rise  <= '0;
        state_q[c].fall  <= '0;
        state_q[c].width <= WidthReset;
      end
    end else if (s1_adv && in_range) begin
      state_q[ch_idx] <= nxt_state;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv || !out_stall_i) begin
      out_valid_q <= s1_adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_chan_q  <= s1_chan_q;
      out_width_q <= in_range ? nxt_state.width : '0;
      out_upd_q   <= in_range && updated;
      out_fall_q  <= in_range && nxt_state.phase;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_chan_o      = out_chan_q;
  assign pulse_width_o   = out_width_q;
  assign width_updated_o = out_upd_q;
  assign awaiting_fall_o = out_fall_q;

endmodule

// ----- tb/rc_pwm_pulse_width_capture_tb.sv -----
// ----------------------------------------------------------------------------
// RC servo pulse width capture testbench
// Drives timestamped edge events and width reads into the capture block and
// checks every result against a cycle-free model of the channel logic. The
// run starts with a directed pulse train and then moves through several
// acceptance windows, from the reset windows to fully open, inverted and
// degenerate ones. Each window gets well-formed pulse trains with random
// timing, plus noise edges and reads. Random gaps and stalls fall on both
// handshakes.
// ----------------------------------------------------------------------------
module rc_pwm_pulse_width_capture_tb;
  import rcpw_pkg::*;

  // Two copies of the model state: one follows accepted transactions, the
  // other runs ahead while the stimulus is planned.
  localparam int PRED = 0;
  localparam int PLAN = 1;
  localparam int RANDOM_PER_PHASE = 122;
  localparam int DRAIN_CYCLES = 6;
  localparam int unsigned CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic             req;
    logic [ChanW-1:0] chan;
    logic [TimeW-1:0] stamp;
  } capture_req_t;

  typedef struct packed {
    logic [ChanW-1:0] chan;
    logic [TimeW-1:0] width;
    logic             updated;
    logic             awaiting;
  } capture_rpt_t;

  typedef struct packed {
    cfg_idx_e         idx;
    logic [TimeW-1:0] data;
  } reg_write_t;

  // Clock, reset and block ports.
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             req_type = REQ_EDGE;
  logic [ChanW-1:0] chan_index = '0;
  logic [TimeW-1:0] edge_time = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ChanW-1:0] out_chan;
  logic [TimeW-1:0] pulse_width;
  logic             width_updated;
  logic             awaiting_fall;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_idx_e         cfg_index = CFG_MIN_ON;
  logic [TimeW-1:0] cfg_data = '0;

  // Model state, stimulus and expected results.
  window_cfg_t  windows [2];
  chan_state_t  chans [2][NUM_CHANNELS];
  capture_req_t pending_reqs [$];
  capture_rpt_t width_reports_q [$];
  reg_write_t   reg_writes_q [$];

  int          mismatches = 0;
  int          in_gap = 0;
  int          stall_left = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  int unsigned cycles = 0;

  rc_pwm_pulse_width_capture dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .req_type_i      (req_type),
    .chan_index_i    (chan_index),
    .edge_time_i     (edge_time),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .out_chan_o      (out_chan),
    .pulse_width_o   (pulse_width),
    .width_updated_o (width_updated),
    .awaiting_fall_o (awaiting_fall),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Ticks from an older capture to a newer one. A wrap, or two equal
  // captures, counts from the top of the timer range.
  function automatic logic [TimeW-1:0] tick_span(logic [TimeW-1:0] older,
                                                 logic [TimeW-1:0] newer);
    if (newer > older) return newer - older;
    return 16'hFFFF - older + newer;
  endfunction

  // Capture value that lies the given span after a base capture.
  function automatic logic [TimeW-1:0] time_after(logic [TimeW-1:0] base,
                                                  logic [TimeW-1:0] span);
    if (span != 0 && ({1'b0, base} + span) <= 17'h0FFFF) return base + span;
    return base + span + 16'd1;
  endfunction

  function automatic void reset_copy(int cp);
    windows[cp] = '{MinOnReset, MaxOnReset, MinOffReset, MaxOffReset};
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      chans[cp][c] = '{1'b0, 16'd0, 16'd0, WidthReset};
    end
  endfunction

  function automatic void set_window(int cp, cfg_idx_e idx, logic [TimeW-1:0] data);
    case (idx)
      CFG_MIN_ON: begin
        windows[cp].min_on = data;
      end
      CFG_MAX_ON: begin
        windows[cp].max_on = data;
      end
      CFG_MIN_OFF: begin
        windows[cp].min_off = data;
      end
      default: begin
        windows[cp].max_off = data;
      end
    endcase
  endfunction

  // One transaction through the channel logic of the given model copy.
  function automatic capture_rpt_t servo_step(int cp, capture_req_t rq);
    capture_rpt_t rpt;
    chan_state_t  st;
    window_cfg_t  w;
    logic [TimeW-1:0] span;
    rpt = '0;
    rpt.chan = rq.chan;
    if (rq.chan >= NUM_CHANNELS) return rpt;
    st = chans[cp][rq.chan];
    w = windows[cp];
    if (rq.req == REQ_EDGE) begin
      if (!st.phase) begin
        // Rising edge: the low gap since the last fall must fit its window.
        st.rise = rq.stamp;
        span = tick_span(st.fall, rq.stamp);
        if (span >= w.min_off && span <= w.max_off) st.phase = 1'b1;
      end else begin
        // Falling edge: a high time inside its window becomes the new width.
        st.fall = rq.stamp;
        span = tick_span(st.rise, rq.stamp);
        if (span >= w.min_on && span <= w.max_on) begin
          st.width = span;
          st.phase = 1'b0;
          rpt.updated = 1'b1;
        end
      end
    end
    chans[cp][rq.chan] = st;
    rpt.width = st.width;
    rpt.awaiting = st.phase;
    return rpt;
  endfunction

  // Idle length: mostly none or short, now and then long, and none at all
  // during a calm stretch.
  function automatic int pick_idle(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_req(logic req, int ch, logic [TimeW-1:0] stamp);
    capture_req_t rq;
    rq.req = req;
    rq.chan = ChanW'(ch);
    rq.stamp = stamp;
    void'(servo_step(PLAN, rq));
    pending_reqs.push_back(rq);
  endtask

  // Mostly edges that continue the channel's pulse train, some of them with
  // spans outside the window, plus reads and edges at random times.
  task automatic push_random();
    int r;
    int ch;
    int lo;
    int hi;
    chan_state_t st;
    logic [TimeW-1:0] span;
    logic [TimeW-1:0] base;
    r = $urandom_range(0, 99);
    ch = $urandom_range(0, NUM_CHANNELS - 1);
    st = chans[PLAN][ch];
    if (r < 12) begin
      push_req(REQ_READ, ch, TimeW'($urandom_range(0, 16'hFFFF)));
    end else if (r < 25) begin
      push_req(REQ_EDGE, ch, TimeW'($urandom_range(0, 16'hFFFF)));
    end else begin
      lo = st.phase ? windows[PLAN].min_on : windows[PLAN].min_off;
      hi = st.phase ? windows[PLAN].max_on : windows[PLAN].max_off;
      base = st.phase ? st.rise : st.fall;
      if (lo <= hi && $urandom_range(0, 9) != 0) span = TimeW'($urandom_range(lo, hi));
      else span = TimeW'($urandom_range(0, 16'hFFFF));
      push_req(REQ_EDGE, ch, time_after(base, span));
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || width_reports_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_random_phase();
    for (int n = 0; n < RANDOM_PER_PHASE; n++) push_random();
    wait_drained();
  endtask

  // Writes all four window registers; called only while the block is idle.
  task automatic program_windows(window_cfg_t w);
    reg_writes_q.push_back('{CFG_MIN_ON, w.min_on});
    reg_writes_q.push_back('{CFG_MAX_ON, w.max_on});
    reg_writes_q.push_back('{CFG_MIN_OFF, w.min_off});
    reg_writes_q.push_back('{CFG_MAX_OFF, w.max_off});
    windows[PLAN] = w;
    while (reg_writes_q.size() != 0 || cfg_valid) begin
      @(negedge clk);
    end
  endtask

  // Input driver: holds a transaction until accepted, then idles or sends
  // the next pending one.
  always @(posedge clk) begin : drive_requests
    capture_req_t nxt;
    logic         nxt_valid;
    if (rst_n) begin
      nxt.req = req_type;
      nxt.chan = chan_index;
      nxt.stamp = edge_time;
      nxt_valid = in_valid;
      if (in_valid && !in_stall) begin
        width_reports_q.push_back(servo_step(PRED, nxt));
        nxt_valid = 1'b0;
      end
      if ($urandom_range(0, 199) == 0) in_calm = !in_calm;
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_reqs.size() != 0) begin
          nxt = pending_reqs.pop_front();
          nxt_valid = 1'b1;
          in_gap = pick_idle(in_calm);
        end
      end
      in_valid <= nxt_valid;
      req_type <= nxt.req;
      chan_index <= nxt.chan;
      edge_time <= nxt.stamp;
    end
  end

  // Configuration driver: the predictor takes each write when it is accepted.
  always @(posedge clk) begin : drive_windows
    reg_write_t wr;
    logic       wr_valid;
    if (rst_n) begin
      wr.idx = cfg_index;
      wr.data = cfg_data;
      wr_valid = cfg_valid;
      if (cfg_valid && cfg_ready) begin
        set_window(PRED, cfg_index, cfg_data);
        wr_valid = 1'b0;
      end
      if (!wr_valid && reg_writes_q.size() != 0) begin
        wr = reg_writes_q.pop_front();
        wr_valid = 1'b1;
      end
      cfg_valid <= wr_valid;
      cfg_index <= wr.idx;
      cfg_data <= wr.data;
    end
  end

  // Result monitor and output stall generator.
  always @(posedge clk) begin : watch_results
    capture_rpt_t got;
    capture_rpt_t want;
    logic         stall_next;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_chan, pulse_width, width_updated, awaiting_fall};
        if (width_reports_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual chan %0d width %0d",
                   $time, got.chan, got.width);
          mismatches++;
        end else begin
          want = width_reports_q.pop_front();
          check_field("out_chan", want.chan, got.chan);
          check_field("pulse_width", want.width, got.width);
          check_field("width_updated", want.updated, got.updated);
          check_field("awaiting_fall", want.awaiting, got.awaiting);
        end
      end
      if ($urandom_range(0, 199) == 0) out_calm = !out_calm;
      stall_next = (stall_left > 0);
      if (stall_next) stall_left--;
      else stall_left = pick_idle(out_calm);
      out_stall <= stall_next;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rc_pwm_pulse_width_capture verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    window_cfg_t w;
    reset_copy(PRED);
    reset_copy(PLAN);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pulse trains under the reset windows: both window boundaries,
    // spans just outside, equal captures, a timer wrap inside a pulse, and
    // reads that must ignore the capture value.
    push_req(REQ_READ, 0, 16'hFFFF);
    push_req(REQ_EDGE, 0, 16'd0);
    push_req(REQ_EDGE, 0, 16'd1000);
    push_req(REQ_EDGE, 0, 16'd1950);
    push_req(REQ_EDGE, 0, 16'd23950);
    push_req(REQ_EDGE, 0, 16'd26025);
    push_req(REQ_EDGE, 0, 16'd48026);
    push_req(REQ_EDGE, 0, 16'd27024);
    push_req(REQ_EDGE, 2, 16'd20000);
    push_req(REQ_EDGE, 2, 16'd21500);
    push_req(REQ_EDGE, 2, 16'd41500);
    push_req(REQ_EDGE, 2, 16'd43000);
    push_req(REQ_EDGE, 2, 16'd65000);
    push_req(REQ_EDGE, 2, 16'd965);
    push_req(REQ_EDGE, 3, 16'hFFFF);
    push_req(REQ_EDGE, 3, 16'd3000);
    push_req(REQ_EDGE, 3, 16'd3000);
    push_req(REQ_READ, 3, 16'd0);
    push_req(REQ_READ, 1, 16'h5555);
    push_req(REQ_READ, 2, 16'hAAAA);
    push_req(REQ_READ, 0, 16'd0);
    run_random_phase();

    // Fully open windows.
    program_windows('{16'd0, 16'hFFFF, 16'd0, 16'hFFFF});
    run_random_phase();

    // Inverted windows reject every interval.
    program_windows('{16'd3000, 16'd2000, 16'd5000, 16'd100});
    run_random_phase();

    // Single-value windows.
    program_windows('{16'd1500, 16'd1500, 16'd4000, 16'd4000});
    run_random_phase();

    // Degenerate windows at the ends of the range.
    program_windows('{16'hFFFF, 16'hFFFF, 16'd0, 16'd0});
    run_random_phase();

    // Two random window settings.
    repeat (2) begin
      w.min_on = TimeW'($urandom_range(0, 3000));
      w.max_on = TimeW'(w.min_on + $urandom_range(0, 2000));
      w.min_off = TimeW'($urandom_range(0, 20000));
      w.max_off = TimeW'(w.min_off + $urandom_range(0, 20000));
      program_windows(w);
      run_random_phase();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("rc_pwm_pulse_width_capture verification clean");
    end else begin
      $display("rc_pwm_pulse_width_capture verification failed");
    end
    $finish;
  end

endmodule
